[rtl/assert_macros.svh]
// Assertion helpers shared by the queue and back-stage RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be seen at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

[rtl/amrf_pkg.sv]
package amrf_pkg;

   // Longest advertisement in bytes; selected records carry at most MAX_ADV_LEN-1 payload bytes.
   localparam int MAX_ADV_LEN = 31;

   localparam logic [7:0] MANUF_TYPE = 8'hFF;
   localparam logic [7:0] MIN_PAYLOAD = 8'd3;
   localparam logic [7:0] MAX_PAYLOAD = 8'(MAX_ADV_LEN - 1);

   // Parser phases.
   localparam logic [1:0] PHASE_LEN     = 2'd0;
   localparam logic [1:0] PHASE_TYPE    = 2'd1;
   localparam logic [1:0] PHASE_PAYLOAD = 2'd2;

   // Configuration register indexes.
   localparam logic CSR_FILTER_ANY = 1'b0;
   localparam logic CSR_FILTER_ID  = 1'b1;

   typedef struct packed {
      logic        filter_any;
      logic [15:0] filter_id;
   } amrf_cfg_type;

   // One queued result. When pair is set, the low ID byte goes out first
   // as byte index zero, followed by the byte described here.
   typedef struct packed {
      logic        pair;
      logic [15:0] maker_id;
      logic [7:0]  data_byte;
      logic [4:0]  byte_index;
      logic [4:0]  record_length;
      logic        last_of_record;
      logic        truncated;
   } amrf_entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } amrf_fifo_status_type;

endpackage

[rtl/adv_manufacturer_record_filter_core.sv]
// Manufacturer-record filter for advertising data.
// Input channel (req_*): one advertising byte per transfer, with req_end_of_adv
// set on the final byte of an advertisement. Output channel (rsp_*): one payload
// byte of a selected manufacturer record per transfer, with its ID, index,
// record length and last/truncated marks. Configuration (csr_*): register 0 is
// filter_any, register 1 is filter_id; the user must write them only while the
// block is idle, and the block itself has no check for this. Throughput is one
// input byte per cycle unless the queue is full. A byte is classified by the
// parser in the cycle it is accepted and its result enters a four-entry queue,
// then the output register that drives rsp_*. The byte that completes a
// manufacturer ID yields two results from one queue entry, the low ID byte
// first; the first ID byte yields none, so the output side keeps pace with the
// input. Reset clears the parser, the queue and the output stage, and sets
// filter_any to 1 and filter_id to 0. When the receiver stalls, the output
// register holds, results collect in the queue and req_ready drops only once
// the queue is full; nothing is dropped.
module adv_manufacturer_record_filter_core import amrf_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_adv_byte,
   input  logic        req_end_of_adv,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_maker_id,
   output logic [7:0]  rsp_data_byte,
   output logic [4:0]  rsp_byte_index,
   output logic [4:0]  rsp_record_length,
   output logic        rsp_last_of_record,
   output logic        rsp_truncated,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   // Filter registers; they keep their values across advertisements.
   amrf_cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FILTER_ANY: cfg_in.filter_any = csr_wdata[0];
            CSR_FILTER_ID:  cfg_in.filter_id  = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.filter_any <= 1'b1;
         cfg_ff.filter_id  <= 16'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front parser pushes at most one queue entry per accepted byte.
   amrf_entry_type       push_entry;
   amrf_entry_type       head;
   amrf_fifo_status_type fifo_status;
   logic                 push;
   logic                 pop;

   amrf_front u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .req_valid      (req_valid),
      .req_adv_byte   (req_adv_byte),
      .req_end_of_adv (req_end_of_adv),
      .req_ready      (req_ready),
      .fifo_status    (fifo_status),
      .push           (push),
      .push_entry     (push_entry)
   );

   amrf_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (fifo_status)
   );

   // The back stage expands paired entries and holds the output register.
   amrf_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .fifo_status        (fifo_status),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_maker_id       (rsp_maker_id),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_byte_index     (rsp_byte_index),
      .rsp_record_length  (rsp_record_length),
      .rsp_last_of_record (rsp_last_of_record),
      .rsp_truncated      (rsp_truncated)
   );

endmodule

[rtl/amrf_front.sv]
module amrf_front import amrf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  amrf_cfg_type   cfg,
   input  logic           req_valid,
   input  logic [7:0]     req_adv_byte,
   input  logic           req_end_of_adv,
   output logic           req_ready,
   input  amrf_fifo_status_type fifo_status,
   output logic           push,
   output amrf_entry_type push_entry
);

   logic [1:0] phase_ff, phase_in;
   logic [7:0] bytes_left_ff, bytes_left_in;
   logic [7:0] plen_ff, plen_in;
   logic [7:0] pos_ff, pos_in;
   logic       sel_ff, sel_in;
   logic [7:0] id_low_ff, id_low_in;
   logic [7:0] id_high_ff, id_high_in;
   logic       matched_ff, matched_in;
   logic       stopped_ff, stopped_in;

   logic       accept;
   logic       last;
   logic       fin;
   logic       trunc;
   logic       id_ok;
   logic [7:0] bl_dec;

   assign req_ready = !fifo_status.full;
   assign accept = req_valid && req_ready;

   assign last   = (bytes_left_ff <= 8'd1);
   assign fin    = last || req_end_of_adv;
   assign trunc  = req_end_of_adv && !last;
   assign id_ok  = cfg.filter_any || ({req_adv_byte, id_low_ff} == cfg.filter_id);
   assign bl_dec = bytes_left_ff - {7'd0, (bytes_left_ff != 8'd0)};

   always_comb begin
      phase_in      = phase_ff;
      bytes_left_in = bytes_left_ff;
      plen_in       = plen_ff;
      pos_in        = pos_ff;
      sel_in        = sel_ff;
      id_low_in     = id_low_ff;
      id_high_in    = id_high_ff;
      matched_in    = matched_ff;
      stopped_in    = stopped_ff;
      push          = 1'b0;
      push_entry.pair           = 1'b0;
      push_entry.maker_id       = {id_high_ff, id_low_ff};
      push_entry.data_byte      = req_adv_byte;
      push_entry.byte_index     = pos_ff[4:0];
      push_entry.record_length  = plen_ff[4:0];
      push_entry.last_of_record = fin;
      push_entry.truncated      = trunc;

      if (accept) begin
         if (!stopped_ff) begin
            case (phase_ff)
               PHASE_TYPE: begin
                  if (plen_ff == 8'd0) begin
                     phase_in = PHASE_LEN;
                  end else begin
                     sel_in = (req_adv_byte == MANUF_TYPE) && (plen_ff >= MIN_PAYLOAD)
                              && (plen_ff <= MAX_PAYLOAD);
                     matched_in    = 1'b0;
                     pos_in        = 8'd0;
                     bytes_left_in = plen_ff;
                     phase_in      = PHASE_PAYLOAD;
                  end
               end
               PHASE_PAYLOAD: begin
                  if (sel_ff) begin
                     if (pos_ff == 8'd0) begin
                        id_low_in = req_adv_byte;
                     end else if (pos_ff == 8'd1) begin
                        id_high_in = req_adv_byte;
                        matched_in = id_ok;
                        if (id_ok) begin
                           push = 1'b1;
                           push_entry.pair     = 1'b1;
                           push_entry.maker_id = {req_adv_byte, id_low_ff};
                        end
                     end else if (matched_ff) begin
                        push = 1'b1;
                     end
                  end
                  pos_in        = pos_ff + 8'd1;
                  bytes_left_in = bl_dec;
                  if (bl_dec == 8'd0) begin
                     phase_in   = PHASE_LEN;
                     sel_in     = 1'b0;
                     matched_in = 1'b0;
                  end
               end
               default: begin
                  if (req_adv_byte == 8'd0) begin
                     stopped_in = 1'b1;
                  end else begin
                     plen_in  = req_adv_byte - 8'd1;
                     phase_in = PHASE_TYPE;
                  end
               end
            endcase
         end
         if (req_end_of_adv) begin
            phase_in      = PHASE_LEN;
            bytes_left_in = 8'd0;
            plen_in       = 8'd0;
            pos_in        = 8'd0;
            sel_in        = 1'b0;
            id_low_in     = 8'd0;
            id_high_in    = 8'd0;
            matched_in    = 1'b0;
            stopped_in    = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PHASE_LEN;
         bytes_left_ff <= 8'd0;
         plen_ff       <= 8'd0;
         pos_ff        <= 8'd0;
         sel_ff        <= 1'b0;
         id_low_ff     <= 8'd0;
         id_high_ff    <= 8'd0;
         matched_ff    <= 1'b0;
         stopped_ff    <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         bytes_left_ff <= bytes_left_in;
         plen_ff       <= plen_in;
         pos_ff        <= pos_in;
         sel_ff        <= sel_in;
         id_low_ff     <= id_low_in;
         id_high_ff    <= id_high_in;
         matched_ff    <= matched_in;
         stopped_ff    <= stopped_in;
      end
   end

endmodule

[rtl/amrf_fifo.sv]
`include "assert_macros.svh"

module amrf_fifo import amrf_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  amrf_entry_type       push_entry,
   input  logic                 pop,
   output amrf_entry_type       head,
   output amrf_fifo_status_type status
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LastPtr = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FullCount = CW'(DEPTH);

   amrf_entry_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == FullCount);
   assign head = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `ASSERT_NEVER(a_no_overflow, clock, reset, push && status.full && !pop, "queue overflow")
   `ASSERT_NEVER(a_no_underflow, clock, reset, pop && status.empty, "queue underflow")
   `ASSERT_CLK(a_count_bound, clock, reset, count_ff <= FullCount, "queue count out of range")

endmodule

[rtl/amrf_back.sv]
`include "assert_macros.svh"

module amrf_back import amrf_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  amrf_entry_type       head,
   input  amrf_fifo_status_type fifo_status,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [15:0]          rsp_maker_id,
   output logic [7:0]           rsp_data_byte,
   output logic [4:0]           rsp_byte_index,
   output logic [4:0]           rsp_record_length,
   output logic                 rsp_last_of_record,
   output logic                 rsp_truncated
);

   logic           valid_ff, valid_in;
   logic           half_ff, half_in;
   logic           load;
   logic           take;
   amrf_entry_type out_ff, out_in;

   assign load = !valid_ff || rsp_ready;
   assign take = load && !fifo_status.empty;

   always_comb begin
      valid_in = valid_ff;
      half_in  = half_ff;
      out_in   = out_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = !fifo_status.empty;
         if (take) begin
            out_in = head;
            if (head.pair && !half_ff) begin
               // Low ID byte of a matching record goes out first.
               out_in.data_byte      = head.maker_id[7:0];
               out_in.byte_index     = 5'd0;
               out_in.last_of_record = 1'b0;
               out_in.truncated      = 1'b0;
               half_in = 1'b1;
            end else begin
               pop     = 1'b1;
               half_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         half_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         half_ff  <= half_in;
      end
      out_ff <= out_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_maker_id       = out_ff.maker_id;
   assign rsp_data_byte      = out_ff.data_byte;
   assign rsp_byte_index     = out_ff.byte_index;
   assign rsp_record_length  = out_ff.record_length;
   assign rsp_last_of_record = out_ff.last_of_record;
   assign rsp_truncated      = out_ff.truncated;

   `ASSERT_CLK(a_half_pair, clock, reset, half_ff |-> head.pair && !fifo_status.empty, "no pair")
   `ASSERT_CLK(a_half_valid, clock, reset, half_ff |-> valid_ff, "low ID byte not shown")
   `ASSERT_NEVER(a_half_index, clock, reset, half_ff && out_ff.byte_index != 5'd0, "bad index")

endmodule
